### design/fspc_pkg.sv
// shared types and codes of the five-stage pipeline core
package fspc_pkg;

    localparam int MEM_BYTES  = 256;
    localparam int REG_COUNT  = 16;

    // item operation codes
    localparam logic [2:0] OPER_LOAD_INSTR = 3'd0;
    localparam logic [2:0] OPER_LOAD_DATA  = 3'd1;
    localparam logic [2:0] OPER_LOAD_REG   = 3'd2;
    localparam logic [2:0] OPER_RUN        = 3'd3;
    localparam logic [2:0] OPER_READ_DATA  = 3'd4;
    localparam logic [2:0] OPER_READ_REG   = 3'd5;

    // instruction opcodes
    localparam logic [3:0] OPC_ADD  = 4'd0;
    localparam logic [3:0] OPC_SUB  = 4'd1;
    localparam logic [3:0] OPC_MUL  = 4'd2;
    localparam logic [3:0] OPC_INC  = 4'd3;
    localparam logic [3:0] OPC_AND  = 4'd4;
    localparam logic [3:0] OPC_OR   = 4'd5;
    localparam logic [3:0] OPC_NOT  = 4'd6;
    localparam logic [3:0] OPC_XOR  = 4'd7;
    localparam logic [3:0] OPC_LD   = 4'd8;
    localparam logic [3:0] OPC_ST   = 4'd9;
    localparam logic [3:0] OPC_JMP  = 4'd10;
    localparam logic [3:0] OPC_BRZ  = 4'd11;
    localparam logic [3:0] OPC_STOP = 4'd15;

    // event counter slots
    localparam logic [2:0] CNT_CYCLES = 3'd0;
    localparam logic [2:0] CNT_ARITH  = 3'd1;
    localparam logic [2:0] CNT_LOGIC  = 3'd2;
    localparam logic [2:0] CNT_MEM    = 3'd3;
    localparam logic [2:0] CNT_CTRL   = 3'd4;
    localparam logic [2:0] CNT_HALT   = 3'd5;
    localparam logic [2:0] CNT_HAZARD = 3'd6;
    localparam logic [2:0] CNT_BRANCH = 3'd7;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] mem_address;
        logic [3:0] reg_index;
        logic [7:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_value;
        logic        is_halted;
        logic [31:0] cycles_run;
        logic [31:0] arith_retired;
        logic [31:0] logic_retired;
        logic [31:0] memory_retired;
        logic [31:0] control_retired;
        logic [31:0] halts_decoded;
        logic [31:0] hazard_stalls;
        logic [31:0] branch_stalls;
    } t_out_item;

endpackage

### design/five_stage_pipeline_core_top.sv
// top level of the five-stage pipeline core with its item handshake
// A run item advances all five pipeline stages by one tick, unless the core
// has halted, in a single combinational pass between the state registers;
// other items load or read the memories and registers. The result item
// appears in the output register on the following cycle and a new item is
// taken every cycle unless that register holds a result that is still
// stalled. After reset the input stays stalled while a clearing pass zeroes
// one row of each memory per cycle.
module five_stage_pipeline_core_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fspc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fspc_pkg::t_out_item o_out_data
);

    logic r_out_valid;
    logic accept;
    logic core_ready;

    // input is held while memories clear or a finished result waits
    assign o_in_stall = ~core_ready | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    fspc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (accept),
        .i_item   (i_in_data),
        .o_ready  (core_ready),
        .o_result (o_out_data)
    );

    assign o_out_valid = r_out_valid;

endmodule

### design/fspc_core.sv
// pipeline state, memories and one-pass tick logic of the core
module fspc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  fspc_pkg::t_in_item  i_item,
    output logic                o_ready,
    output fspc_pkg::t_out_item o_result
);

    typedef struct packed {
        logic [15:0] ir;
        logic        valid;
    } t_dec;

    typedef struct packed {
        logic [15:0] ir;
        logic [7:0]  pc;
        logic [7:0]  a;
        logic [7:0]  b;
        logic        valid;
    } t_exe;

    typedef struct packed {
        logic [15:0] ir;
        logic [7:0]  ao;
        logic        valid;
    } t_mem;

    typedef struct packed {
        logic [15:0] ir;
        logic [7:0]  ao;
        logic [7:0]  lmd;
        logic        valid;
    } t_wb;

    // memories: instruction bytes split into even and odd banks
    logic [7:0]   r_imem_hi [fspc_pkg::MEM_BYTES/2];
    logic [7:0]   r_imem_lo [fspc_pkg::MEM_BYTES/2];
    logic [7:0]   r_dmem [fspc_pkg::MEM_BYTES];
    logic         r_clr_on;
    logic [7:0]   r_clr_idx;

    logic [7:0]   r_regs [fspc_pkg::REG_COUNT];
    logic [7:0]   n_regs [fspc_pkg::REG_COUNT];
    logic [15:0]  r_busy, n_busy;
    logic [7:0]   r_pc, n_pc;
    logic         r_fen, n_fen;
    t_dec         r_dec, n_dec;
    t_exe         r_exe, n_exe;
    t_mem         r_mem, n_mem;
    t_wb          r_wb, n_wb;
    logic         r_sd, n_sd;
    logic         r_se, n_se;
    logic         r_halt, n_halt;
    logic [31:0]  r_cnt [8];
    logic [31:0]  n_cnt [8];
    logic [1:0]   cnt_add [8];
    fspc_pkg::t_out_item r_res;

    logic         run;
    logic [3:0]   op;
    logic [3:0]   dst;
    logic [15:0]  mir;
    logic [7:0]   mao;
    logic [3:0]   rd_f, ra_f, rb_f;
    logic         st_do, ld_do, fetch_do;
    logic [7:0]   st_addr, st_data, ld_addr, fetch_addr;
    logic [6:0]   fetch_row;
    logic [7:0]   rd_reg_val;

    function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] amt);
        logic [32:0] s;
        s = {1'b0, v} + {31'b0, amt};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign run = i_go && (i_item.operation == fspc_pkg::OPER_RUN);

    // one tick: writeback, memory, execute, decode, fetch in order
    always_comb begin
        n_regs   = r_regs;
        n_busy   = r_busy;
        n_pc     = r_pc;
        n_fen    = r_fen;
        n_dec    = r_dec;
        n_exe    = r_exe;
        n_mem    = r_mem;
        n_wb     = r_wb;
        n_sd     = r_sd;
        n_se     = r_se;
        n_halt   = r_halt;
        for (int k = 0; k < 8; k++) begin
            cnt_add[k] = 2'd0;
        end
        op         = 4'd0;
        dst        = 4'd0;
        mir        = 16'd0;
        mao        = 8'd0;
        rd_f       = 4'd0;
        ra_f       = 4'd0;
        rb_f       = 4'd0;
        st_do      = 1'b0;
        ld_do      = 1'b0;
        fetch_do   = 1'b0;
        st_addr    = 8'd0;
        st_data    = 8'd0;
        ld_addr    = 8'd0;
        fetch_addr = 8'd0;

        if (i_go && i_item.operation == fspc_pkg::OPER_LOAD_REG) begin
            n_regs[i_item.reg_index] = i_item.write_value;
        end

        if (run && !r_halt) begin
            cnt_add[fspc_pkg::CNT_CYCLES] = 2'd1;

            // writeback
            if (n_wb.valid) begin
                op  = n_wb.ir[15:12];
                dst = n_wb.ir[11:8];
                n_wb.valid = 1'b0;
                if (op == fspc_pkg::OPC_STOP) begin
                    n_halt = 1'b1;
                end else begin
                    if (dst != 4'd0) begin
                        n_regs[dst] = (op == fspc_pkg::OPC_LD) ? n_wb.lmd : n_wb.ao;
                    end
                    n_busy[dst] = 1'b0;
                end
            end

            // memory
            if (n_mem.valid) begin
                mir = n_mem.ir;
                mao = n_mem.ao;
                n_mem.valid = 1'b0;
                op = mir[15:12];
                if (op == fspc_pkg::OPC_STOP) begin
                    n_wb.ir    = mir;
                    n_wb.valid = 1'b1;
                end else if (op == fspc_pkg::OPC_JMP || op == fspc_pkg::OPC_BRZ) begin
                    if (n_pc == mao) begin
                        n_dec.valid = 1'b0;
                        n_sd = 1'b0;
                        n_se = 1'b0;
                    end else begin
                        n_pc  = mao;
                        n_fen = 1'b1;
                        n_dec = '0;
                        n_exe = '0;
                        n_mem = '0;
                        n_wb  = '0;
                        n_sd  = 1'b0;
                        n_se  = 1'b0;
                    end
                    n_wb.valid = 1'b0;
                end else if (op == fspc_pkg::OPC_ST) begin
                    st_do   = 1'b1;
                    st_addr = mao;
                    st_data = n_regs[mir[11:8]];
                    n_wb    = '0;
                    n_wb.valid = 1'b1;
                end else if (op == fspc_pkg::OPC_LD) begin
                    ld_do   = 1'b1;
                    ld_addr = mao;
                    n_wb.ir = mir;
                    n_wb.ao = mao;
                    n_wb.valid = 1'b1;
                end else begin
                    n_wb.ir  = mir;
                    n_wb.ao  = mao;
                    n_wb.lmd = 8'd0;
                    n_wb.valid = 1'b1;
                end
            end

            // execute
            if (n_exe.valid && !n_se) begin
                op = n_exe.ir[15:12];
                case (op)
                    fspc_pkg::OPC_ADD: begin
                        n_mem.ao = n_exe.a + n_exe.b;
                        cnt_add[fspc_pkg::CNT_ARITH] = 2'd1;
                    end
                    fspc_pkg::OPC_SUB: begin
                        n_mem.ao = n_exe.a - n_exe.b;
                        cnt_add[fspc_pkg::CNT_ARITH] = 2'd1;
                    end
                    fspc_pkg::OPC_MUL: begin
                        n_mem.ao = n_exe.a * n_exe.b;
                        cnt_add[fspc_pkg::CNT_ARITH] = 2'd1;
                    end
                    fspc_pkg::OPC_INC: begin
                        n_mem.ao = n_exe.a + 8'd1;
                        cnt_add[fspc_pkg::CNT_ARITH] = 2'd1;
                    end
                    fspc_pkg::OPC_AND: begin
                        n_mem.ao = n_exe.a & n_exe.b;
                        cnt_add[fspc_pkg::CNT_LOGIC] = 2'd1;
                    end
                    fspc_pkg::OPC_OR: begin
                        n_mem.ao = n_exe.a | n_exe.b;
                        cnt_add[fspc_pkg::CNT_LOGIC] = 2'd1;
                    end
                    fspc_pkg::OPC_NOT: begin
                        n_mem.ao = ~n_exe.a;
                        cnt_add[fspc_pkg::CNT_LOGIC] = 2'd1;
                    end
                    fspc_pkg::OPC_XOR: begin
                        n_mem.ao = n_exe.a ^ n_exe.b;
                        cnt_add[fspc_pkg::CNT_LOGIC] = 2'd1;
                    end
                    fspc_pkg::OPC_LD, fspc_pkg::OPC_ST: begin
                        n_mem.ao = n_exe.a + n_exe.b;
                        cnt_add[fspc_pkg::CNT_MEM] = 2'd1;
                    end
                    fspc_pkg::OPC_JMP: begin
                        n_se = 1'b1;
                        cnt_add[fspc_pkg::CNT_CTRL] = 2'd1;
                        n_mem.ao = n_exe.pc + {n_exe.a[6:0], 1'b0};
                    end
                    fspc_pkg::OPC_BRZ: begin
                        n_se = 1'b1;
                        cnt_add[fspc_pkg::CNT_CTRL] = 2'd1;
                        n_mem.ao = (n_exe.a == 8'd0) ? n_exe.pc + {n_exe.b[6:0], 1'b0}
                                                     : n_exe.pc;
                    end
                    default: begin
                        // unused opcodes keep the previous alu output
                        n_mem.ao = n_mem.ao;
                    end
                endcase
                n_mem.ir    = n_exe.ir;
                n_mem.valid = 1'b1;
                n_exe.valid = 1'b0;
            end

            // decode
            if (n_dec.valid && !n_sd && !n_exe.valid && !n_se) begin
                op   = n_dec.ir[15:12];
                rd_f = n_dec.ir[11:8];
                ra_f = n_dec.ir[7:4];
                rb_f = n_dec.ir[3:0];
                n_exe.ir    = n_dec.ir;
                n_dec.valid = 1'b0;
                n_exe.valid = 1'b1;
                case (op)
                    fspc_pkg::OPC_STOP: begin
                        n_fen = 1'b0;
                        cnt_add[fspc_pkg::CNT_HALT] = 2'd1;
                    end
                    fspc_pkg::OPC_JMP: begin
                        n_sd     = 1'b1;
                        n_exe.a  = n_dec.ir[11:4];
                        n_exe.pc = n_pc;
                        cnt_add[fspc_pkg::CNT_BRANCH] = 2'd2;
                    end
                    fspc_pkg::OPC_BRZ: begin
                        if (n_busy[rd_f]) begin
                            cnt_add[fspc_pkg::CNT_HAZARD] = 2'd1;
                            n_exe.valid = 1'b0;
                            n_dec.valid = 1'b1;
                        end else begin
                            n_sd     = 1'b1;
                            cnt_add[fspc_pkg::CNT_BRANCH] = 2'd2;
                            n_exe.pc = n_pc;
                            n_exe.a  = n_regs[rd_f];
                            n_exe.b  = n_dec.ir[7:0];
                        end
                    end
                    fspc_pkg::OPC_LD, fspc_pkg::OPC_ST: begin
                        if (n_busy[ra_f]) begin
                            cnt_add[fspc_pkg::CNT_HAZARD] = 2'd1;
                            n_exe.valid = 1'b0;
                            n_dec.valid = 1'b1;
                        end else begin
                            n_exe.a = n_regs[ra_f];
                            n_exe.b = {4'd0, rb_f};
                            if (op == fspc_pkg::OPC_LD) begin
                                n_busy[rd_f] = 1'b1;
                            end
                        end
                    end
                    fspc_pkg::OPC_INC: begin
                        if (n_busy[rd_f]) begin
                            cnt_add[fspc_pkg::CNT_HAZARD] = 2'd1;
                            n_exe.valid = 1'b0;
                            n_dec.valid = 1'b1;
                        end else begin
                            n_exe.a = n_regs[rd_f];
                            n_busy[rd_f] = 1'b1;
                        end
                    end
                    fspc_pkg::OPC_NOT: begin
                        if (n_busy[ra_f]) begin
                            cnt_add[fspc_pkg::CNT_HAZARD] = 2'd1;
                            n_exe.valid = 1'b0;
                            n_dec.valid = 1'b1;
                        end else begin
                            n_exe.a = n_regs[ra_f];
                            n_busy[rd_f] = 1'b1;
                        end
                    end
                    default: begin
                        if (n_busy[ra_f] || n_busy[rb_f]) begin
                            cnt_add[fspc_pkg::CNT_HAZARD] = 2'd1;
                            n_exe.valid = 1'b0;
                            n_dec.valid = 1'b1;
                        end else begin
                            n_exe.a = n_regs[ra_f];
                            n_exe.b = n_regs[rb_f];
                            n_busy[rd_f] = 1'b1;
                        end
                    end
                endcase
            end

            // fetch: the word itself is read from the banks at the clock edge
            if (n_fen && !n_dec.valid && !n_sd) begin
                fetch_do    = 1'b1;
                fetch_addr  = n_pc;
                n_dec.valid = 1'b1;
                n_pc        = n_pc + 8'd2;
            end
        end

        for (int k = 0; k < 8; k++) begin
            n_cnt[k] = sat_add(r_cnt[k], cnt_add[k]);
        end
    end

    assign fetch_row  = fetch_addr[7:1];
    assign rd_reg_val = r_regs[i_item.reg_index];

    // control and pipeline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fspc_pkg::REG_COUNT; k++) begin
                r_regs[k] <= 8'd0;
            end
            for (int k = 0; k < 8; k++) begin
                r_cnt[k] <= 32'd0;
            end
            r_busy <= '0;
            r_pc   <= 8'd0;
            r_fen  <= 1'b1;
            r_dec  <= '0;
            r_exe  <= '0;
            r_mem  <= '0;
            r_wb   <= '0;
            r_sd   <= 1'b0;
            r_se   <= 1'b0;
            r_halt <= 1'b0;
        end else if (i_go) begin
            r_regs <= n_regs;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_fen  <= n_fen;
            r_exe  <= n_exe;
            r_mem  <= n_mem;
            r_sd   <= n_sd;
            r_se   <= n_se;
            r_halt <= n_halt;
            r_dec.valid <= n_dec.valid;
            r_dec.ir    <= fetch_do ? {r_imem_hi[fetch_row], r_imem_lo[fetch_row]}
                                    : n_dec.ir;
            r_wb.ir     <= n_wb.ir;
            r_wb.ao     <= n_wb.ao;
            r_wb.valid  <= n_wb.valid;
            r_wb.lmd    <= ld_do ? r_dmem[ld_addr] : n_wb.lmd;
        end
    end

    // clearing pass over all memory rows after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_on  <= 1'b1;
            r_clr_idx <= 8'd0;
        end else if (r_clr_on) begin
            r_clr_idx <= r_clr_idx + 8'd1;
            if (r_clr_idx == 8'hFF) begin
                r_clr_on <= 1'b0;
            end
        end
    end

    assign o_ready = ~r_clr_on;

    // memory arrays
    always_ff @(posedge i_clk) begin
        if (r_clr_on) begin
            r_dmem[r_clr_idx]         <= 8'd0;
            r_imem_hi[r_clr_idx[6:0]] <= 8'd0;
            r_imem_lo[r_clr_idx[6:0]] <= 8'd0;
        end else if (i_go) begin
            if (i_item.operation == fspc_pkg::OPER_LOAD_INSTR) begin
                if (i_item.mem_address[0]) begin
                    r_imem_lo[i_item.mem_address[7:1]] <= i_item.write_value;
                end else begin
                    r_imem_hi[i_item.mem_address[7:1]] <= i_item.write_value;
                end
            end
            if (i_item.operation == fspc_pkg::OPER_LOAD_DATA) begin
                r_dmem[i_item.mem_address] <= i_item.write_value;
            end else if (st_do) begin
                r_dmem[st_addr] <= st_data;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            case (i_item.operation)
                fspc_pkg::OPER_READ_DATA: begin
                    r_res.read_value <= r_dmem[i_item.mem_address];
                end
                fspc_pkg::OPER_READ_REG: begin
                    r_res.read_value <= rd_reg_val;
                end
                default: begin
                    r_res.read_value <= 8'd0;
                end
            endcase
            r_res.is_halted       <= n_halt;
            r_res.cycles_run      <= n_cnt[fspc_pkg::CNT_CYCLES];
            r_res.arith_retired   <= n_cnt[fspc_pkg::CNT_ARITH];
            r_res.logic_retired   <= n_cnt[fspc_pkg::CNT_LOGIC];
            r_res.memory_retired  <= n_cnt[fspc_pkg::CNT_MEM];
            r_res.control_retired <= n_cnt[fspc_pkg::CNT_CTRL];
            r_res.halts_decoded   <= n_cnt[fspc_pkg::CNT_HALT];
            r_res.hazard_stalls   <= n_cnt[fspc_pkg::CNT_HAZARD];
            r_res.branch_stalls   <= n_cnt[fspc_pkg::CNT_BRANCH];
        end
    end

    assign o_result = r_res;

endmodule

### design/fspc_checker.sv
// port-level checks of the five-stage pipeline core
module fspc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fspc_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a waiting result always holds back the input
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while a result waits");

    // every accepted item gives a result on the next cycle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

    // halt is sticky across results
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && o_out_data.is_halted) && o_out_valid
        |-> o_out_data.is_halted)
        else $error("halt flag cleared");

    // cycle count never goes back
    a_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid) && o_out_valid
        |-> o_out_data.cycles_run >= $past(o_out_data.cycles_run))
        else $error("cycle count decreased");

endmodule

bind five_stage_pipeline_core_top fspc_checker u_fspc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
